// ===== rtl/core/bb_pkg.sv =====
// ----------------------------------------------------------------------------
// bb_pkg: shared types and constants of the 3x3 box blur
// Pixel, window column and beat payload types, register codes and the
// arithmetic helpers used by the window cells and the output stage.
// ----------------------------------------------------------------------------
package bb_pkg;

  // Field widths fixed by the pixel format and the register port.
  localparam int PIX_W       = 8;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 1;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  // Register values after reset.
  localparam int FRAME_WIDTH_RESET  = 640;
  localparam int FRAME_HEIGHT_RESET = 480;

  // Window sums: nine 8-bit values fit in 12 bits.
  localparam int SUM_W = 12;

  // Division by nine as a multiply by round(2^16 / 9) and a shift. The
  // error stays below 1/100 over the whole sum range, so truncation is exact.
  localparam int              DIV9_W     = 13;
  localparam logic [DIV9_W-1:0] DIV9_MUL = 13'd7282;
  localparam int              DIV9_SHIFT = 16;

  // Number of stored columns in the window chain.
  localparam int WIN_CELLS = 2;

  // Output queue.
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } bb_pix_t;

  // One window column, oldest row on top.
  typedef struct packed {
    bb_pix_t top;
    bb_pix_t mid;
    bb_pix_t bot;
  } bb_col_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } bb_acc_t;

  // One line buffer entry: the two previous rows at one column.
  typedef struct packed {
    bb_pix_t prev2;
    bb_pix_t prev;
  } bb_lines_t;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;
  } bb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             end_of_frame;
  } bb_out_t;

  // Per-channel sum of the three pixels of a column.
  function automatic bb_acc_t col_sum(input bb_col_t c);
    bb_acc_t s;
    s.red   = SUM_W'(c.top.red)   + SUM_W'(c.mid.red)   + SUM_W'(c.bot.red);
    s.green = SUM_W'(c.top.green) + SUM_W'(c.mid.green) + SUM_W'(c.bot.green);
    s.blue  = SUM_W'(c.top.blue)  + SUM_W'(c.mid.blue)  + SUM_W'(c.bot.blue);
    return s;
  endfunction

  function automatic bb_acc_t acc_add(input bb_acc_t a, input bb_acc_t b);
    bb_acc_t s;
    s.red   = a.red + b.red;
    s.green = a.green + b.green;
    s.blue  = a.blue + b.blue;
    return s;
  endfunction

  // Truncating division of a window sum by nine.
  function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+DIV9_W-1:0] prod;
    prod = (SUM_W+DIV9_W)'(s) * (SUM_W+DIV9_W)'(DIV9_MUL);
    return prod[DIV9_SHIFT +: PIX_W];
  endfunction

endpackage

// ===== rtl/core/bb_stream_if.sv =====
// ----------------------------------------------------------------------------
// bb_stream_if: valid/ready stream channel
// Carries one payload per beat; a beat moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface bb_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/core/bb_cell.sv =====
// ----------------------------------------------------------------------------
// bb_cell: one stored column of the 3x3 window
// Takes the column of its left neighbour on each pixel beat and adds its
// own column sum to the running window sum passed along the chain.
// ----------------------------------------------------------------------------
module bb_cell (
  input  logic            clk,
  input  logic            shift,
  input  bb_pkg::bb_col_t col_in,
  output bb_pkg::bb_col_t col,
  input  bb_pkg::bb_acc_t acc_in,
  output bb_pkg::bb_acc_t acc_out
);

  // The column moves one place along the chain per pixel beat.
  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

  // Running window sum over this cell and the ones before it.
  assign acc_out = bb_pkg::acc_add(acc_in, bb_pkg::col_sum(col));

endmodule

// ===== rtl/core/bb_linebuf.sv =====
// ----------------------------------------------------------------------------
// bb_linebuf: two-row line buffer
// Holds the two previous rows at each column in one memory. The read is
// registered; a write to the same column in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module bb_linebuf #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output bb_pkg::bb_lines_t        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  bb_pkg::bb_lines_t        wr_data
);

  bb_pkg::bb_lines_t mem [DEPTH];
  bb_pkg::bb_lines_t rd_q;
  bb_pkg::bb_lines_t fwd_data;
  logic              fwd;

  // Read-first memory port pair.
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Catch a write that lands on the column being read in the same cycle.
  always_ff @(posedge clk) begin
    fwd      <= wr_en && (wr_addr == rd_addr);
    fwd_data <= wr_data;
  end

  assign rd_data = fwd ? fwd_data : rd_q;

endmodule

// ===== rtl/core/bb_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bb_out_fifo: result queue
// Small register queue between the filter pipeline and the result channel,
// so that a waiting result does not hold up the input side.
// ----------------------------------------------------------------------------
module bb_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  bb_pkg::bb_out_t                 push_data,
  input  logic                            pop,
  output bb_pkg::bb_out_t                 head,
  output logic [bb_pkg::FIFO_CNT_W-1:0]   count
);

  bb_pkg::bb_out_t                  entries [bb_pkg::FIFO_DEPTH];
  logic [bb_pkg::FIFO_PTR_W-1:0]    wr_ptr;
  logic [bb_pkg::FIFO_PTR_W-1:0]    rd_ptr;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head = entries[rd_ptr];

endmodule

// ===== rtl/core/box_blur_3x3_top.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_top: streaming 3x3 box blur on RGB pixels
// Raster-order pixels in; per-channel 3x3 mean of interior pixels out,
// border pixels unchanged. Drain beats flush the tail of a frame.
// ----------------------------------------------------------------------------
//
//   channel   dir   protocol       beat contents
//   -------   ---   ------------   ----------------------------------------
//   pixels    in    valid/ready    mode, pixel_red, pixel_green, pixel_blue
//   results   out   valid/ready    out_red, out_green, out_blue, end_of_frame
//   cfg       in    write enable   cfg_index, cfg_data (no read-back)
//
// One input beat is taken per cycle when ready. A result is registered in
// the window and divide stages before the queue; it lags its own pixel by
// one row and one pixel. Reset is synchronous and needs no clearing pass:
// the line buffer is only used where written. When the result channel
// stalls, a four-entry queue absorbs results in flight and input ready drops
// only once the queue and pipeline together would overflow it.
//
module box_blur_3x3_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [bb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bb_pkg::CFG_DATA_W-1:0]    cfg_data,
  bb_stream_if.sink                        pixels,
  bb_stream_if.source                      results
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = $clog2(MAX_WIDTH + 2);
  localparam int RESET_W = (bb_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
                           MAX_WIDTH : bb_pkg::FRAME_WIDTH_RESET;
  localparam int RESET_H = (bb_pkg::FRAME_HEIGHT_RESET > MAX_HEIGHT) ?
                           MAX_HEIGHT : bb_pkg::FRAME_HEIGHT_RESET;

  // Frame size, held already limited to the supported range.
  logic [WW-1:0] frame_w;
  logic [HW-1:0] frame_h;
  logic [WW-1:0] w_clamped;
  logic [HW-1:0] h_clamped;
  logic [AW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic          cfg_hit;

  // Stream position and pending count.
  logic [AW-1:0] in_col, in_col_next;
  logic [RW-1:0] in_row, in_row_next;
  logic [AW-1:0] out_col, out_col_next;
  logic [RW-1:0] out_row, out_row_next;
  logic [PW-1:0] pending, pending_next;

  logic accept;
  logic pix_beat;
  logic full_lag;
  logic drain_ok;
  logic emit;
  logic interior;
  logic last_out;

  // Window stage.
  logic              b_pix;
  logic              b_emit;
  logic              b_drain;
  logic              b_sel2;
  logic              b_interior;
  logic              b_eof;
  bb_pkg::bb_pix_t   b_px;
  logic [AW-1:0]     b_col;

  // Divide stage.
  logic              c_emit;
  logic              c_interior;
  logic              c_eof;
  bb_pkg::bb_acc_t   c_sum;
  bb_pkg::bb_pix_t   c_own;

  // Line buffer and window chain.
  logic [AW-1:0]     rd_addr;
  bb_pkg::bb_lines_t lines;
  bb_pkg::bb_lines_t lines_wr;
  bb_pkg::bb_col_t   cell_col [bb_pkg::WIN_CELLS+1];
  bb_pkg::bb_acc_t   cell_acc [bb_pkg::WIN_CELLS+1];
  bb_pkg::bb_pix_t   own_px;

  // Result queue.
  bb_pkg::bb_out_t                 res;
  logic [bb_pkg::FIFO_CNT_W-1:0]   fifo_count;
  logic [bb_pkg::FIFO_CNT_W-1:0]   in_flight;

  // Register writes are limited: zero acts as one, large values as the maximum.
  always_comb begin
    if (cfg_data == '0) begin
      w_clamped = WW'(1);
    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
      w_clamped = WW'(MAX_WIDTH);
    end else begin
      w_clamped = WW'(cfg_data);
    end
    if (cfg_data == '0) begin
      h_clamped = HW'(1);
    end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
      h_clamped = HW'(MAX_HEIGHT);
    end else begin
      h_clamped = HW'(cfg_data);
    end
  end

  always_comb begin
    case (cfg_index)
      bb_pkg::CFG_FRAME_WIDTH:  cfg_hit = cfg_wr_en;
      bb_pkg::CFG_FRAME_HEIGHT: cfg_hit = cfg_wr_en;
      default:                  cfg_hit = 1'b0;
    endcase
  end

  assign wm1 = AW'(frame_w - WW'(1));
  assign hm1 = RW'(frame_h - HW'(1));

  // Input side: room is kept in the queue for every result still in flight.
  assign in_flight = fifo_count + bb_pkg::FIFO_CNT_W'(b_emit)
                                + bb_pkg::FIFO_CNT_W'(c_emit);
  assign pixels.ready = in_flight < bb_pkg::FIFO_CNT_W'(bb_pkg::FIFO_DEPTH);
  assign accept       = pixels.valid && pixels.ready;
  assign pix_beat     = accept && !pixels.payload.mode;

  // A pixel beat releases a result once a full row and one pixel are held;
  // a drain beat releases one only at the start of a frame.
  assign full_lag = pending > PW'(frame_w);
  assign drain_ok = (in_col == '0) && (in_row == '0) && (pending != '0);
  assign emit     = accept && (pixels.payload.mode ? drain_ok : full_lag);

  assign interior = (out_row != '0) && (out_row != hm1) &&
                    (out_col != '0) && (out_col != wm1);
  assign last_out = (out_row == hm1) && (out_col == wm1);

  // Next stream positions.
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    pending_next = pending;
    if (pix_beat) begin
      if (in_col == wm1) begin
        in_col_next = '0;
        in_row_next = (in_row == hm1) ? '0 : in_row + 1'b1;
      end else begin
        in_col_next = in_col + 1'b1;
      end
    end
    if (emit) begin
      if (out_col == wm1) begin
        out_col_next = '0;
        out_row_next = (out_row == hm1) ? '0 : out_row + 1'b1;
      end else begin
        out_col_next = out_col + 1'b1;
      end
    end
    if (pix_beat && !emit) begin
      pending_next = pending + 1'b1;
    end else if (!pix_beat && emit) begin
      pending_next = pending - 1'b1;
    end
  end

  // Control registers; a register write restarts the stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w <= WW'(RESET_W);
      frame_h <= HW'(RESET_H);
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pending <= '0;
      b_pix   <= 1'b0;
      b_emit  <= 1'b0;
      c_emit  <= 1'b0;
    end else begin
      b_pix  <= pix_beat;
      b_emit <= emit;
      c_emit <= b_emit;
      if (cfg_hit) begin
        case (cfg_index)
          bb_pkg::CFG_FRAME_WIDTH:  frame_w <= w_clamped;
          bb_pkg::CFG_FRAME_HEIGHT: frame_h <= h_clamped;
          default:                  frame_w <= frame_w;
        endcase
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        pending <= '0;
      end else begin
        in_col  <= in_col_next;
        in_row  <= in_row_next;
        out_col <= out_col_next;
        out_row <= out_row_next;
        pending <= pending_next;
      end
    end
  end

  // Beat payload into the window stage.
  always_ff @(posedge clk) begin
    b_px.red   <= pixels.payload.pixel_red;
    b_px.green <= pixels.payload.pixel_green;
    b_px.blue  <= pixels.payload.pixel_blue;
    b_col      <= in_col;
    b_drain    <= pixels.payload.mode;
    b_sel2     <= full_lag;
    b_interior <= interior;
    b_eof      <= last_out;
  end

  // A drain reads the pending pixel straight from the line buffer.
  assign rd_addr = pixels.payload.mode ? out_col : in_col;

  always_comb begin
    lines_wr.prev2 = lines.prev;
    lines_wr.prev  = b_px;
  end

  bb_linebuf #(
    .DEPTH (MAX_WIDTH)
  ) u_linebuf (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (lines),
    .wr_en   (b_pix),
    .wr_addr (b_col),
    .wr_data (lines_wr)
  );

  // Incoming column: two rows from the line buffer and the new pixel.
  always_comb begin
    cell_col[0].top = lines.prev2;
    cell_col[0].mid = lines.prev;
    cell_col[0].bot = b_px;
  end
  assign cell_acc[0] = bb_pkg::col_sum(cell_col[0]);

  for (genvar g = 0; g < bb_pkg::WIN_CELLS; g++) begin : g_cell
    bb_cell u_cell (
      .clk     (clk),
      .shift   (b_pix),
      .col_in  (cell_col[g]),
      .col     (cell_col[g+1]),
      .acc_in  (cell_acc[g]),
      .acc_out (cell_acc[g+1])
    );
  end

  // The centre of the window is the pixel being given out.
  always_comb begin
    if (!b_drain) begin
      own_px = cell_col[1].mid;
    end else if (b_sel2) begin
      own_px = lines.prev2;
    end else begin
      own_px = lines.prev;
    end
  end

  always_ff @(posedge clk) begin
    c_sum      <= cell_acc[bb_pkg::WIN_CELLS];
    c_own      <= own_px;
    c_interior <= b_interior && !b_drain;
    c_eof      <= b_eof;
  end

  // Divide by nine for interior pixels, pass border pixels.
  always_comb begin
    if (c_interior) begin
      res.out_red   = bb_pkg::div9(c_sum.red);
      res.out_green = bb_pkg::div9(c_sum.green);
      res.out_blue  = bb_pkg::div9(c_sum.blue);
    end else begin
      res.out_red   = c_own.red;
      res.out_green = c_own.green;
      res.out_blue  = c_own.blue;
    end
    res.end_of_frame = c_eof;
  end

  bb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (c_emit),
    .push_data (res),
    .pop       (results.valid && results.ready),
    .head      (results.payload),
    .count     (fifo_count)
  );

  assign results.valid = fifo_count != '0;

endmodule

// ===== tb/tb_box_blur_3x3_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_top: self-checking bench for the streaming 3x3 box blur
// Feeds raster-order pixel beats and drain beats through the pixel channel,
// predicts every result with an independent line-buffer model of the filter,
// and compares each result beat field by field in arrival order. Both channel
// sides idle and stall at random; frame sizes are changed between phases.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_top;

  localparam int          MAX_W         = 2048;
  localparam int          MAX_H         = 2048;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          RESET_PIXELS  = 48;
  localparam int          RANDOM_ITEMS  = 480;
  localparam int          STEADY_ITEMS  = 150;
  localparam int unsigned RUN_LIMIT_NS  = 10_000_000;

  // Beat kinds on the pixel channel.
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  logic                           clk;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [bb_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bb_pkg::CFG_DATA_W-1:0]  cfg_data;

  bb_stream_if #(.payload_t(bb_pkg::bb_in_t))  pixel_ch ();
  bb_stream_if #(.payload_t(bb_pkg::bb_out_t)) result_ch ();

  box_blur_3x3_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixel_ch),
    .results   (result_ch)
  );

  // Prediction state: three rotating rows of pixels plus stream positions.
  bb_pkg::bb_pix_t               row_buf [3][MAX_W];
  logic [bb_pkg::CFG_DATA_W-1:0] reg_width;
  logic [bb_pkg::CFG_DATA_W-1:0] reg_height;
  int unsigned                   wr_row, wr_col, wr_bank;
  int unsigned                   rd_row, rd_col, rd_bank;
  int unsigned                   backlog;
  bb_pkg::bb_out_t               expected_out_pix [$];

  // Bookkeeping.
  bit              no_gaps;
  int unsigned     mismatches;
  int unsigned     counted_items;
  int unsigned     pixel_beats;
  int unsigned     drain_beats;
  int unsigned     results_seen;
  int unsigned     reg_writes;
  bb_pkg::bb_out_t got_pix;
  bb_pkg::bb_out_t want_pix;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the pipeline hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    result_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 35);
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      got_pix = result_ch.payload;
      results_seen++;
      if (expected_out_pix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result at %0t: r=%0d g=%0d b=%0d eof=%0b", $time,
                   got_pix.out_red, got_pix.out_green, got_pix.out_blue,
                   got_pix.end_of_frame);
      end else begin
        want_pix = expected_out_pix.pop_front();
        if (got_pix.out_red !== want_pix.out_red ||
            got_pix.out_green !== want_pix.out_green ||
            got_pix.out_blue !== want_pix.out_blue ||
            got_pix.end_of_frame !== want_pix.end_of_frame) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: expected r=%0d g=%0d b=%0d eof=%0b,",
                     $time, want_pix.out_red, want_pix.out_green,
                     want_pix.out_blue, want_pix.end_of_frame);
            $display("  got r=%0d g=%0d b=%0d eof=%0b", got_pix.out_red,
                     got_pix.out_green, got_pix.out_blue, got_pix.end_of_frame);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // A zero register acts as one; anything above the maximum acts as the maximum.
  function automatic int unsigned active_dim(input logic [bb_pkg::CFG_DATA_W-1:0] v,
                                             input int unsigned lim);
    if (v == '0) return 1;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  function automatic void restart_positions();
    wr_row  = 0;
    wr_col  = 0;
    wr_bank = 0;
    rd_row  = 0;
    rd_col  = 0;
    rd_bank = 0;
    backlog = 0;
  endfunction

  function automatic void apply_register(input logic [bb_pkg::CFG_INDEX_W-1:0] idx,
                                         input logic [bb_pkg::CFG_DATA_W-1:0] val);
    if (idx == bb_pkg::CFG_FRAME_WIDTH)
      reg_width = val;
    else
      reg_height = val;
    restart_positions();
  endfunction

  // Produce the output for the oldest pending pixel and advance the read side.
  function automatic void produce_result(input int unsigned w, input int unsigned h);
    bb_pkg::bb_pix_t centre;
    bb_pkg::bb_pix_t nb;
    bb_pkg::bb_out_t res;
    int unsigned     banks [3];
    int unsigned     sr, sg, sb;
    centre        = row_buf[rd_bank][rd_col];
    res.out_red   = centre.red;
    res.out_green = centre.green;
    res.out_blue  = centre.blue;
    if (rd_row >= 1 && rd_row + 1 < h && rd_col >= 1 && rd_col + 1 < w) begin
      banks[0] = (rd_bank + 2) % 3;
      banks[1] = rd_bank;
      banks[2] = (rd_bank + 1) % 3;
      sr = 0;
      sg = 0;
      sb = 0;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          nb = row_buf[banks[i]][rd_col - 1 + k];
          sr += nb.red;
          sg += nb.green;
          sb += nb.blue;
        end
      end
      res.out_red   = 8'(sr / 9);
      res.out_green = 8'(sg / 9);
      res.out_blue  = 8'(sb / 9);
    end
    res.end_of_frame = (rd_row + 1 == h) && (rd_col + 1 == w);
    expected_out_pix.push_back(res);
    rd_col++;
    if (rd_col >= w) begin
      rd_col  = 0;
      rd_bank = (rd_bank + 1) % 3;
      rd_row++;
      if (rd_row >= h) rd_row = 0;
    end
    backlog--;
  endfunction

  // Update the model with one accepted beat; returns 1 when it yields a result.
  function automatic bit predict_blur(input bb_pkg::bb_in_t beat);
    int unsigned     w;
    int unsigned     h;
    bb_pkg::bb_pix_t px;
    w = active_dim(reg_width, MAX_W);
    h = active_dim(reg_height, MAX_H);
    if (beat.mode == MODE_PIXEL) begin
      px.red   = beat.pixel_red;
      px.green = beat.pixel_green;
      px.blue  = beat.pixel_blue;
      row_buf[wr_bank][wr_col] = px;
      wr_col++;
      if (wr_col >= w) begin
        wr_col  = 0;
        wr_bank = (wr_bank + 1) % 3;
        wr_row++;
        if (wr_row >= h) wr_row = 0;
      end
      backlog++;
      if (backlog > w + 1) begin
        produce_result(w, h);
        return 1'b1;
      end
      return 1'b0;
    end
    // A drain only flushes once the input side sits at the start of a frame.
    if (wr_row == 0 && wr_col == 0 && backlog > 0) begin
      produce_result(w, h);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one beat with random idle cycles ahead of it, then update the model.
  task automatic send_beat(input bb_pkg::bb_in_t beat);
    bit made;
    while (!no_gaps && $urandom_range(0, 99) < 35) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid   <= 1'b1;
    pixel_ch.payload <= beat;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    made = predict_blur(beat);
    if (beat.mode == MODE_PIXEL) pixel_beats++;
    else drain_beats++;
    if (beat.mode == MODE_PIXEL || made) counted_items++;
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    bb_pkg::bb_in_t beat;
    beat.mode        = MODE_PIXEL;
    beat.pixel_red   = r;
    beat.pixel_green = g;
    beat.pixel_blue  = b;
    send_beat(beat);
  endtask

  // Drain beats carry random channel values, which the block must ignore.
  task automatic send_drain();
    bb_pkg::bb_in_t beat;
    beat             = bb_pkg::bb_in_t'($bits(bb_pkg::bb_in_t)'($urandom));
    beat.mode        = MODE_DRAIN;
    send_beat(beat);
  endtask

  // Random pixels, a quarter of them built only from zero and full-scale channel values.
  task automatic send_frame(input int unsigned n_pix, input bit with_noise);
    logic [7:0] ch [3];
    for (int unsigned n = 0; n < n_pix; n++) begin
      if (with_noise && $urandom_range(0, 99) < 4) send_drain();
      if ($urandom_range(0, 3) == 0) begin
        for (int c = 0; c < 3; c++) ch[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        for (int c = 0; c < 3; c++) ch[c] = 8'($urandom_range(0, 255));
      end
      send_pixel(ch[0], ch[1], ch[2]);
    end
  endtask

  // Flush the tail of a completed frame, optionally with spare drain beats.
  task automatic flush_frame(input int unsigned spare);
    while (backlog > 0 && wr_row == 0 && wr_col == 0) send_drain();
    repeat (spare) send_drain();
  endtask

  // Stop sending and hold off until every predicted result has arrived.
  task automatic wait_drained();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_out_pix.size() != 0) @(posedge clk);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic write_reg(input logic [bb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bb_pkg::CFG_DATA_W-1:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_register(idx, val);
    reg_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_size(input logic [bb_pkg::CFG_DATA_W-1:0] w,
                          input logic [bb_pkg::CFG_DATA_W-1:0] h);
    write_reg(bb_pkg::CFG_FRAME_WIDTH, w);
    write_reg(bb_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // At the reset size of 640 pixels per row the first pixels give no result.
  task automatic test_reset_size();
    send_frame(RESET_PIXELS, 1'b0);
  endtask

  // One interior pixel per frame: full scale, a lone bright centre with
  // truncation, a drain inside the frame, and a frame that follows without
  // a drain in between.
  task automatic test_single_window();
    set_size(3, 3);
    repeat (9) send_pixel(8'hFF, 8'hFF, 8'hFF);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_drain();
      if (i == 4) send_pixel(8'hFF, 8'hFF, 8'hFF);
      else send_pixel(8'h00, 8'h00, 8'h00);
    end
    flush_frame(1);
  endtask

  // Frames with fewer than three rows or columns pass every pixel through.
  task automatic test_small_frames();
    set_size(1, 1);
    send_frame(1, 1'b0);
    flush_frame(1);
    set_size(2, 5);
    send_frame(10, 1'b0);
    flush_frame(0);
    set_size(5, 2);
    send_frame(10, 1'b0);
    flush_frame(0);
    set_size(0, 3);
    send_frame(3, 1'b0);
    flush_frame(1);
    set_size(3, 1);
    send_frame(3, 1'b0);
    flush_frame(0);
  endtask

  // A register write in mid-frame throws away what is still pending.
  task automatic test_restart();
    set_size(4, 4);
    send_frame(7, 1'b0);
    write_reg(bb_pkg::CFG_FRAME_HEIGHT, 4);
    send_frame(16, 1'b0);
    flush_frame(0);
  endtask

  // Random frame sizes and contents; some frames run back to back, some are
  // cut short, and now and then the sender holds off until all is drained.
  task automatic test_random_frames();
    int unsigned start_items;
    int unsigned w, h, frames, r;
    bit          cut_short;
    start_items = counted_items;
    no_gaps     = 1'b1;
    while (counted_items - start_items < RANDOM_ITEMS) begin
      if (counted_items - start_items >= STEADY_ITEMS) no_gaps = 1'b0;
      r = $urandom_range(0, 99);
      w = (r < 5) ? 0 : (r < 12) ? $urandom_range(8, 24) : $urandom_range(1, 7);
      r = $urandom_range(0, 99);
      h = (r < 5) ? 0 : (r < 12) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      set_size(bb_pkg::CFG_DATA_W'(w), bb_pkg::CFG_DATA_W'(h));
      w = active_dim(bb_pkg::CFG_DATA_W'(w), MAX_W);
      h = active_dim(bb_pkg::CFG_DATA_W'(h), MAX_H);
      frames    = $urandom_range(1, 3);
      cut_short = 1'b0;
      while (frames > 0 && !cut_short) begin
        if ($urandom_range(0, 19) == 0) begin
          send_frame($urandom_range(1, w * h), 1'b1);
          cut_short = 1'b1;
        end else begin
          send_frame(w * h, 1'b1);
        end
        frames--;
      end
      if (!cut_short) flush_frame($urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    pixel_ch.valid   = 1'b0;
    pixel_ch.payload = '0;
    result_ch.ready  = 1'b0;
    no_gaps          = 1'b0;
    mismatches       = 0;
    counted_items    = 0;
    pixel_beats      = 0;
    drain_beats      = 0;
    results_seen     = 0;
    reg_writes       = 0;
    reg_width        = bb_pkg::CFG_DATA_W'(bb_pkg::FRAME_WIDTH_RESET);
    reg_height       = bb_pkg::CFG_DATA_W'(bb_pkg::FRAME_HEIGHT_RESET);
    restart_positions();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_size();
    test_single_window();
    test_small_frames();
    test_restart();
    test_random_frames();

    // Let the last results through, then allow for any stray late beat.
    wait_drained();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d pixel beats and %0d drain beats across %0d register writes.",
             pixel_beats, drain_beats, reg_writes);
    $display("Compared %0d result beats; %0d failed.", results_seen, mismatches);
    if (mismatches == 0 && expected_out_pix.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
